### rtl/core/fts_pkg.sv
// Shared constants, codes and types of the FCFS tick scheduler.
package fts_pkg;

  localparam int MAX_PROCS = 16;
  localparam int IDX_W     = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TICK_W    = 8;
  localparam int RID_W     = 4;
  localparam int OCNT_W    = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DISP,
    ST_DISP_WB,
    ST_BURST,
    ST_BURST_WB,
    ST_DONE
  } fts_state_e;

  typedef struct packed {
    logic load;
    logic tick_start;
    logic walk;
    logic disp_wb;
    logic burst_wb;
    logic emit;
  } fts_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic need_disp;
    logic cpu_taken;
    logic out_free;
  } fts_status_t;

endpackage

### rtl/core/fts_if.sv
// Request and result channel interfaces of the FCFS tick scheduler.
interface fts_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] arrival_ticks;
  logic [7:0] burst_ticks;

  modport source (output valid, operation, arrival_ticks, burst_ticks, input ready);
  modport sink   (input valid, operation, arrival_ticks, burst_ticks, output ready);
endinterface

interface fts_res_if;
  logic       valid;
  logic       ready;
  logic       cpu_busy;
  logic [3:0] running_id;
  logic [7:0] burst_shown;
  logic       finished;
  logic [4:0] ready_count;
  logic [4:0] process_count;

  modport source (output valid, cpu_busy, running_id, burst_shown, finished, ready_count,
                  process_count, input ready);
  modport sink   (input valid, cpu_busy, running_id, burst_shown, finished, ready_count,
                  process_count, output ready);
endinterface

### rtl/core/fts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fts_ctrl.sv
// Controller state machine: sequences load, arrival walk, dispatch and burst steps.
module fts_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  input  logic                req_op_i,
  output logic                req_ready_o,
  input  fts_pkg::fts_status_t status_i,
  output fts_pkg::fts_cmd_t    cmd_o
);
  import fts_pkg::*;

  fts_state_e state_q, state_d;
  logic       accept;

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_op_i == OP_TICK) begin
            cmd_o.tick_start = 1'b1;
            state_d          = ST_WALK;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = ST_DONE;
          end
        end
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_done) begin
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        // FIFO head read is in flight this cycle
        state_d = status_i.need_disp ? ST_DISP_WB : ST_BURST;
      end
      ST_DISP_WB: begin
        cmd_o.disp_wb = 1'b1;
        state_d       = ST_BURST;
      end
      ST_BURST: begin
        state_d = status_i.cpu_taken ? ST_BURST_WB : ST_DONE;
      end
      ST_BURST_WB: begin
        cmd_o.burst_wb = 1'b1;
        state_d        = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/fts_dp.sv
// Datapath: process tables, ready FIFO, CPU holder and result register.
module fts_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  fts_pkg::fts_cmd_t          cmd_i,
  output fts_pkg::fts_status_t       status_o,
  input  logic [fts_pkg::TICK_W-1:0] arrival_ticks_i,
  input  logic [fts_pkg::TICK_W-1:0] burst_ticks_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic                       cpu_busy_o,
  output logic [fts_pkg::RID_W-1:0]  running_id_o,
  output logic [fts_pkg::TICK_W-1:0] burst_shown_o,
  output logic                       finished_o,
  output logic [fts_pkg::OCNT_W-1:0] ready_count_o,
  output logic [fts_pkg::OCNT_W-1:0] process_count_o
);
  import fts_pkg::*;

  logic [CNT_W-1:0]     loaded_q, loaded_d;
  logic [CNT_W-1:0]     fill_q, fill_d;
  logic [CNT_W-1:0]     walk_idx_q, walk_idx_d;
  logic [IDX_W-1:0]     head_q, head_d;
  logic [IDX_W-1:0]     tail_q, tail_d;
  logic [IDX_W-1:0]     holder_q, holder_d;
  logic [IDX_W-1:0]     pidx_q, pidx_d;
  logic                 taken_q, taken_d;
  logic                 pv_q, pv_d;
  logic                 out_valid_q, out_valid_d;
  logic [MAX_PROCS-1:0] flag_q, flag_d;
  logic [TICK_W-1:0]    shown_q, shown_d;
  logic                 done_q, done_d;

  logic                 out_busy_q;
  logic [RID_W-1:0]     out_rid_q;
  logic [TICK_W-1:0]    out_shown_q;
  logic                 out_done_q;
  logic [OCNT_W-1:0]    out_ready_cnt_q;
  logic [OCNT_W-1:0]    out_proc_cnt_q;

  logic                 load_ok, walk_issue, proc, push;
  logic [TICK_W-1:0]    arr_dec;

  logic                 arr_we, bur_we, fifo_we;
  logic [IDX_W-1:0]     arr_waddr, bur_waddr;
  logic [TICK_W-1:0]    arr_wdata, bur_wdata;
  logic [TICK_W-1:0]    arr_rdata, bur_rdata;
  logic [IDX_W-1:0]     fifo_rdata;

  assign load_ok    = cmd_i.load && (loaded_q < CNT_W'(MAX_PROCS));
  assign walk_issue = cmd_i.walk && (walk_idx_q < loaded_q);
  assign proc       = cmd_i.walk && pv_q && !flag_q[pidx_q];
  assign arr_dec    = arr_rdata - TICK_W'(1);
  assign push       = proc && (arr_dec == '0) && (fill_q < CNT_W'(MAX_PROCS));

  // arrival countdowns: written on load and by the walk, read at the walk index
  assign arr_we    = load_ok || proc;
  assign arr_waddr = load_ok ? loaded_q[IDX_W-1:0] : pidx_q;
  assign arr_wdata = load_ok ? arrival_ticks_i : arr_dec;

  // remaining bursts: written on load and after each reported nonzero tick
  assign bur_we    = load_ok || (cmd_i.burst_wb && (bur_rdata != '0));
  assign bur_waddr = load_ok ? loaded_q[IDX_W-1:0] : holder_q;
  assign bur_wdata = load_ok ? burst_ticks_i : (bur_rdata - TICK_W'(1));

  assign fifo_we = push;

  fts_ram #(.WIDTH(TICK_W), .DEPTH(MAX_PROCS)) u_arr_ram (
    .clk_i   (clk_i),
    .we_i    (arr_we),
    .waddr_i (arr_waddr),
    .wdata_i (arr_wdata),
    .raddr_i (walk_idx_q[IDX_W-1:0]),
    .rdata_o (arr_rdata)
  );

  fts_ram #(.WIDTH(TICK_W), .DEPTH(MAX_PROCS)) u_bur_ram (
    .clk_i   (clk_i),
    .we_i    (bur_we),
    .waddr_i (bur_waddr),
    .wdata_i (bur_wdata),
    .raddr_i (holder_q),
    .rdata_o (bur_rdata)
  );

  fts_ram #(.WIDTH(IDX_W), .DEPTH(MAX_PROCS)) u_fifo_ram (
    .clk_i   (clk_i),
    .we_i    (fifo_we),
    .waddr_i (tail_q),
    .wdata_i (pidx_q),
    .raddr_i (head_q),
    .rdata_o (fifo_rdata)
  );

  always_comb begin
    loaded_d    = loaded_q;
    fill_d      = fill_q;
    walk_idx_d  = walk_idx_q;
    head_d      = head_q;
    tail_d      = tail_q;
    holder_d    = holder_q;
    pidx_d      = pidx_q;
    taken_d     = taken_q;
    pv_d        = 1'b0;
    flag_d      = flag_q;
    shown_d     = shown_q;
    done_d      = done_q;
    out_valid_d = out_valid_q;

    if (cmd_i.load || cmd_i.tick_start) begin
      shown_d    = '0;
      done_d     = 1'b0;
      walk_idx_d = '0;
    end
    if (load_ok) begin
      flag_d[loaded_q[IDX_W-1:0]] = 1'b0;
      loaded_d                    = loaded_q + CNT_W'(1);
    end

    if (walk_issue) begin
      pv_d       = 1'b1;
      pidx_d     = walk_idx_q[IDX_W-1:0];
      walk_idx_d = walk_idx_q + CNT_W'(1);
    end
    if (push) begin
      flag_d[pidx_q] = 1'b1;
      fill_d         = fill_q + CNT_W'(1);
      tail_d         = (tail_q == IDX_W'(MAX_PROCS - 1)) ? '0 : tail_q + IDX_W'(1);
    end

    if (cmd_i.disp_wb) begin
      holder_d = fifo_rdata;
      taken_d  = 1'b1;
      fill_d   = fill_q - CNT_W'(1);
      head_d   = (head_q == IDX_W'(MAX_PROCS - 1)) ? '0 : head_q + IDX_W'(1);
    end

    if (cmd_i.burst_wb) begin
      shown_d = bur_rdata;
      if (bur_rdata == '0) begin
        done_d  = 1'b1;
        taken_d = 1'b0;
      end
    end

    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q    <= '0;
      fill_q      <= '0;
      walk_idx_q  <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      holder_q    <= '0;
      taken_q     <= 1'b0;
      pv_q        <= 1'b0;
      flag_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      loaded_q    <= loaded_d;
      fill_q      <= fill_d;
      walk_idx_q  <= walk_idx_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      holder_q    <= holder_d;
      taken_q     <= taken_d;
      pv_q        <= pv_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q  <= pidx_d;
    shown_q <= shown_d;
    done_q  <= done_d;
    if (cmd_i.emit) begin
      out_busy_q      <= taken_q;
      out_rid_q       <= (taken_q || done_q) ? RID_W'(holder_q) : '0;
      out_shown_q     <= shown_q;
      out_done_q      <= done_q;
      out_ready_cnt_q <= OCNT_W'(fill_q);
      out_proc_cnt_q  <= OCNT_W'(loaded_q);
    end
  end

  assign status_o.walk_done = !pv_q && (walk_idx_q >= loaded_q);
  assign status_o.need_disp = !taken_q && (fill_q != '0);
  assign status_o.cpu_taken = taken_q;
  assign status_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign cpu_busy_o      = out_busy_q;
  assign running_id_o    = out_rid_q;
  assign burst_shown_o   = out_shown_q;
  assign finished_o      = out_done_q;
  assign ready_count_o   = out_ready_cnt_q;
  assign process_count_o = out_proc_cnt_q;

endmodule

### rtl/core/fcfs_tick_scheduler.sv
// Load request: tables written on accept; ST_DONE registers the result once out_free.
// Tick request: walk, dispatch and burst steps before the result is registered; the walk
//   reads one arrival countdown per cycle from the arrival RAM.
// One request in flight; the next is taken while the result waits in its register.
// Reset (async, active low) clears counts, FIFO pointers, CPU state and arrived flags;
// the RAM tables stay undefined and need no clearing pass.
module fcfs_tick_scheduler (
  input logic     clk_i,
  input logic     rst_ni,
  fts_req_if.sink req_i,
  fts_res_if.source res_o
);
  import fts_pkg::*;

  fts_cmd_t    cmd;
  fts_status_t status;

  // sequencer: idle / walk / dispatch / burst / emit
  fts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_op_i    (req_i.operation),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // tables, ready FIFO, CPU holder and the result register
  fts_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .arrival_ticks_i (req_i.arrival_ticks),
    .burst_ticks_i   (req_i.burst_ticks),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .cpu_busy_o      (res_o.cpu_busy),
    .running_id_o    (res_o.running_id),
    .burst_shown_o   (res_o.burst_shown),
    .finished_o      (res_o.finished),
    .ready_count_o   (res_o.ready_count),
    .process_count_o (res_o.process_count)
  );

  // a finished job has released the CPU
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> !(res_o.finished && res_o.cpu_busy))
    else $error("finished reported while CPU still busy");

  // the ready FIFO never holds more than the loaded processes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (res_o.ready_count <= res_o.process_count))
    else $error("ready count exceeds process count");

  // a nonzero burst shown means the job keeps running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.burst_shown != '0)) |-> (res_o.cpu_busy && !res_o.finished))
    else $error("nonzero burst shown without a running job");

  // an accepted request keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request taken while previous one in progress");

endmodule

### dv/tb.sv
// Self-checking FCFS tick scheduler testbench: directed and random load/tick requests against a predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fts_pkg::*;

  // Counted requests: ticks plus loads that land in the table.
  localparam int ITEMS    = 1150;
  // Cycle budget.
  localparam int LIMIT    = 1_000_000;
  // Long result-side hold: starts once this many results are checked.
  localparam int HOLD_AT  = 400;
  localparam int HOLD_LEN = 300;
  // Window (in counted requests / checked results) with no idling on either side.
  localparam int CALM_LO  = 500;
  localparam int CALM_HI  = 640;

  typedef struct packed {
    logic              cpu_busy;
    logic [RID_W-1:0]  running_id;
    logic [TICK_W-1:0] burst_shown;
    logic              finished;
    logic [OCNT_W-1:0] ready_count;
    logic [OCNT_W-1:0] process_count;
  } status_t;

  // Shadow of the scheduler state. note_request() advances it by one accepted request
  // and queues the expected status; check_status() compares a result with the oldest one.
  class sched_scoreboard;
    logic [TICK_W-1:0] arrival_left [MAX_PROCS];
    logic [TICK_W-1:0] burst_left   [MAX_PROCS];
    bit                arrived      [MAX_PROCS];
    logic [IDX_W-1:0]  ready_ring   [MAX_PROCS];
    int                loaded;
    int                head;
    int                fill;
    logic [IDX_W-1:0]  holder;
    bit                on_cpu;
    status_t           status_q [$];
    int                mismatches;

    function new();
      loaded     = 0;
      head       = 0;
      fill       = 0;
      holder     = '0;
      on_cpu     = 0;
      mismatches = 0;
      foreach (arrived[i]) arrived[i] = 0;
    endfunction

    function int pending();
      return status_q.size();
    endfunction

    function void note_request(logic op, logic [TICK_W-1:0] arr, logic [TICK_W-1:0] bur);
      status_t           s;
      logic [TICK_W-1:0] shown;
      bit                done;
      shown = '0;
      done  = 0;
      if (op == OP_LOAD) begin
        // full table: load dropped
        if (loaded < MAX_PROCS) begin
          arrival_left[loaded] = arr;
          burst_left[loaded]   = bur;
          arrived[loaded]      = 0;
          loaded++;
        end
      end else begin
        // countdown walk in index order; a zero arrival wraps to 255 first
        for (int i = 0; i < loaded; i++) begin
          if (!arrived[i]) begin
            arrival_left[i] = arrival_left[i] - 1'b1;
            if (arrival_left[i] == '0) begin
              arrived[i] = 1;
              if (fill < MAX_PROCS) begin
                ready_ring[(head + fill) % MAX_PROCS] = IDX_W'(i);
                fill++;
              end
            end
          end
        end
        if (!on_cpu && fill > 0) begin
          holder = ready_ring[head];
          head   = (head + 1) % MAX_PROCS;
          fill--;
          on_cpu = 1;
        end
        // report then decrement; done on the tick that shows zero
        if (on_cpu) begin
          shown = burst_left[holder];
          if (shown == '0) begin
            done   = 1;
            on_cpu = 0;
          end else begin
            burst_left[holder] = shown - 1'b1;
          end
        end
      end
      s.cpu_busy      = on_cpu;
      s.running_id    = (on_cpu || done) ? RID_W'(holder) : '0;
      s.burst_shown   = shown;
      s.finished      = done;
      s.ready_count   = OCNT_W'(fill);
      s.process_count = OCNT_W'(loaded);
      status_q.push_back(s);
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_status(status_t got);
      status_t want;
      if (status_q.size() == 0) begin
        $error("status returned with no request pending: %p", got);
        mismatches++;
        return;
      end
      want = status_q.pop_front();
      cmp_field("cpu_busy",      want.cpu_busy,      got.cpu_busy);
      cmp_field("running_id",    want.running_id,    got.running_id);
      cmp_field("burst_shown",   want.burst_shown,   got.burst_shown);
      cmp_field("finished",      want.finished,      got.finished);
      cmp_field("ready_count",   want.ready_count,   got.ready_count);
      cmp_field("process_count", want.process_count, got.process_count);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  fts_req_if req_bus ();
  fts_res_if res_bus ();

  fcfs_tick_scheduler DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  sched_scoreboard sb = new();

  int unsigned cycle_cnt;
  int          checked;     // results compared so far
  int          counted;     // ticks and effective loads accepted
  int          loads_sent;  // loads that landed in the table

  // Idle length: mostly none or short, a few long.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  // Offer one request and hold it until the handshake; then update the shadow.
  task automatic send(input logic op, input logic [7:0] arr, input logic [7:0] bur);
    req_bus.valid         <= 1'b1;
    req_bus.operation     <= op;
    req_bus.arrival_ticks <= arr;
    req_bus.burst_ticks   <= bur;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    sb.note_request(op, arr, bur);
    // loads into a full table are ignored by the block and not counted
    if (op == OP_TICK || loads_sent < MAX_PROCS) counted++;
    if (op == OP_LOAD && loads_sent < MAX_PROCS) loads_sent++;
  endtask

  // Drop valid for an idle of length n; n == 0 keeps valid up for back-to-back requests.
  task automatic pause_req(input int n);
    if (n > 0) begin
      req_bus.valid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // One result-side cycle: sample the handshake with pre-edge values.
  task automatic take_result();
    status_t got;
    @(posedge clk_i);
    if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
      got = {res_bus.cpu_busy, res_bus.running_id, res_bus.burst_shown, res_bus.finished,
             res_bus.ready_count, res_bus.process_count};
      sb.check_status(got);
      checked++;
    end
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Reset once; all block inputs known from time zero.
  initial begin
    rst_ni                <= 1'b0;
    req_bus.valid         <= 1'b0;
    req_bus.operation     <= OP_LOAD;
    req_bus.arrival_ticks <= '0;
    req_bus.burst_ticks   <= '0;
    res_bus.ready         <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("tb: errors");
    $finish;
  end

  // Result side: ready runs and stalls of random length, one long hold so the
  // result register and the single in-flight slot fill and the request side stalls,
  // and a calm window with ready held high.
  initial begin
    int run;
    int stall;
    bit held;
    held    = 0;
    checked = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      res_bus.ready <= 1'b1;
      run = $urandom_range(1, 12);
      repeat (run) take_result();
      if (!held && checked >= HOLD_AT) begin
        held  = 1;
        stall = HOLD_LEN;
      end else if (checked >= CALM_LO && checked < CALM_HI) begin
        stall = 0;
      end else begin
        stall = gap_len();
      end
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        repeat (stall) take_result();
      end
    end
  end

  // Request side
  initial begin
    int         roll;
    logic [7:0] arr;
    logic [7:0] bur;
    counted    = 0;
    loads_sent = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    // --- directed part ---
    // zero burst: arrives on the first tick, shows 0 and finishes at once
    send(OP_LOAD, 8'd1, 8'd0);      pause_req(gap_len());
    send(OP_TICK, 8'hFF, 8'hFF);    pause_req(gap_len());
    // tick with an idle CPU and an empty ready queue
    send(OP_TICK, 8'h00, 8'h00);    pause_req(gap_len());
    // field extremes and alternating bit patterns
    send(OP_LOAD, 8'hFF, 8'hFF);    pause_req(gap_len());
    // zero arrival wraps: arrives 256 ticks later
    send(OP_LOAD, 8'h00, 8'h01);    pause_req(gap_len());
    send(OP_LOAD, 8'h55, 8'hAA);    pause_req(gap_len());
    send(OP_LOAD, 8'hAA, 8'h55);    pause_req(gap_len());
    send(OP_LOAD, 8'd2, 8'd3);      pause_req(gap_len());
    // two processes arriving on the same tick queue in index order
    send(OP_LOAD, 8'd1, 8'd4);      pause_req(gap_len());
    send(OP_LOAD, 8'd1, 8'd2);      pause_req(gap_len());
    repeat (8) begin
      send(OP_TICK, 8'($urandom), 8'($urandom));
      pause_req(gap_len());
    end

    // --- random part ---
    // Loads are scarce (one table, one reset), so they are spread over the early
    // ticks; once the table is full, stray loads act as noise and are not counted.
    while (counted < ITEMS) begin
      roll = $urandom_range(0, 99);
      if (loads_sent < MAX_PROCS && roll < 8) begin
        arr = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(1, 40));
        bur = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 120))
                                          : 8'($urandom_range(0, 25));
        send(OP_LOAD, arr, bur);
      end else if (loads_sent == MAX_PROCS && roll < 6) begin
        send(OP_LOAD, 8'($urandom), 8'($urandom));
      end else begin
        send(OP_TICK, 8'($urandom), 8'($urandom));
      end
      pause_req((counted >= CALM_LO && counted < CALM_HI) ? 0 : gap_len());
    end
    req_bus.valid <= 1'b0;

    // drain, then let any stray result show up
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
